// ----- hw/rtl/oads_pkg.sv -----
// Shared types and constants for the obstacle-avoid drive sequencer.
// Used by oads_cfg_regs, oads_drive_core and obstacle_avoid_drive_sequencer.
package oads_pkg;

  // Converter reading width
  localparam int unsigned SampleBits = 10;
  localparam int unsigned ThreshBits = 10;
  localparam int unsigned LimitBits  = 8;
  localparam int unsigned PinBits    = 5;
  localparam int unsigned CmpBits    = (SampleBits > ThreshBits) ? SampleBits : ThreshBits;

  // Configuration port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 10;

  localparam logic [CfgIdxBits-1:0] RegThreshold = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegRevLimit  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegTurnLimit = 2'd2;

  localparam logic [ThreshBits-1:0] ThresholdRst = 10'd400;
  localparam logic [LimitBits-1:0]  RevLimitRst  = 8'd12;
  localparam logic [LimitBits-1:0]  TurnLimitRst = 8'd5;

  // Event kinds
  localparam logic ModeSample = 1'b0;
  localparam logic ModeButton = 1'b1;

  // Motor port bits: bit0 enable, bits 1..4 bridge lines
  localparam logic [PinBits-1:0] PinEn      = 5'h01;
  localparam logic [PinBits-1:0] FwdClr     = 5'h12;
  localparam logic [PinBits-1:0] FwdSet     = 5'h0D;
  localparam logic [PinBits-1:0] RevClr     = 5'h0C;
  localparam logic [PinBits-1:0] RevSet     = 5'h13;
  localparam logic [PinBits-1:0] RightClr   = 5'h15;
  localparam logic [PinBits-1:0] RightSet   = 5'h0B;
  localparam logic [PinBits-1:0] LeftClr    = 5'h0B;
  localparam logic [PinBits-1:0] LeftSet    = 5'h15;

  localparam logic [LimitBits-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    DRV_STOP  = 3'd0,
    DRV_FWD   = 3'd1,
    DRV_REV   = 3'd2,
    DRV_RIGHT = 3'd3,
    DRV_LEFT  = 3'd4
  } drive_e;

  typedef struct packed {
    logic                  mode;
    logic [SampleBits-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [PinBits-1:0] motor_pins;
    logic               alert_led;
    logic               status_led;
    logic [2:0]         drive_now;
  } out_beat_t;

  typedef struct packed {
    logic [ThreshBits-1:0] threshold;
    logic [LimitBits-1:0]  rev_limit;
    logic [LimitBits-1:0]  turn_limit;
  } cfg_t;

endpackage

// ----- hw/rtl/oads_cfg_regs.sv -----
// Configuration register bank: threshold, reverse and turn limits.
// Depends on oads_pkg.
module oads_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [oads_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [oads_pkg::CfgDataBits-1:0] cfg_data_i,
  output oads_pkg::cfg_t                   cfg_o
);
  import oads_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode write; unknown index leaves everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegThreshold: cfg_d.threshold  = cfg_data_i[ThreshBits-1:0];
        RegRevLimit:  cfg_d.rev_limit  = cfg_data_i[LimitBits-1:0];
        RegTurnLimit: cfg_d.turn_limit = cfg_data_i[LimitBits-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= ThresholdRst;
      cfg_q.rev_limit  <= RevLimitRst;
      cfg_q.turn_limit <= TurnLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/oads_drive_core.sv -----
// Drive state machine: state registers and the one-beat step decode.
// Depends on oads_pkg.
module oads_drive_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oads_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  oads_pkg::in_beat_t  beat_i,
  output oads_pkg::out_beat_t res_o
);
  import oads_pkg::*;

  drive_e                state_q, state_d, state_eff;
  logic [LimitBits-1:0]  count_q, count_d, count_inc;
  logic [SampleBits-1:0] last_q, last_d;
  logic [PinBits-1:0]    pins_q, pins_d;
  logic                  alert_q, alert_d;
  logic                  status_q, status_d;
  logic                  close_hit;

  assign close_hit = CmpBits'(beat_i.sample) > CmpBits'(cfg_i.threshold);
  assign count_inc = (count_q != CountMax) ? count_q + 1'b1 : count_q;

  // Obstacle preempts forward before the drive step
  always_comb begin
    state_eff = state_q;
    if (close_hit && (state_q == DRV_FWD)) state_eff = DRV_STOP;
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    last_d   = last_q;
    status_d = status_q;
    if (beat_i.mode == ModeButton) begin
      status_d = ~status_q;
    end else begin
      last_d   = beat_i.sample;
      status_d = status_q ^ close_hit;
      state_d  = state_eff;
      case (state_eff)
        DRV_STOP: begin
          state_d = DRV_REV;
          count_d = '0;
        end
        DRV_FWD: count_d = count_q;
        DRV_REV: begin
          if (count_inc > cfg_i.rev_limit) begin
            count_d = '0;
            state_d = beat_i.sample[0] ? DRV_RIGHT : DRV_LEFT;
          end else begin
            count_d = count_inc;
          end
        end
        DRV_RIGHT, DRV_LEFT: begin
          if (count_inc > cfg_i.turn_limit) begin
            count_d = '0;
            state_d = DRV_FWD;
          end else begin
            count_d = count_inc;
          end
        end
        default: state_d = DRV_STOP;
      endcase
    end
  end

  // Pin latch and alert
  always_comb begin
    pins_d  = pins_q;
    alert_d = alert_q;
    if (beat_i.mode == ModeSample) begin
      case (state_eff)
        DRV_STOP: begin
          pins_d  = pins_q & ~PinEn;
          alert_d = ~alert_q;
        end
        DRV_FWD: pins_d = (pins_q & ~FwdClr) | FwdSet;
        DRV_REV: if (count_q == '0) pins_d = (pins_q & ~RevClr) | RevSet;
        DRV_RIGHT: if (count_q == '0) pins_d = (pins_q & ~RightClr) | RightSet;
        DRV_LEFT: if (count_q == '0) pins_d = (pins_q & ~LeftClr) | LeftSet;
        default: pins_d = pins_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= DRV_FWD;
      count_q  <= '0;
      last_q   <= '0;
      pins_q   <= '0;
      alert_q  <= 1'b0;
      status_q <= 1'b0;
    end else if (fire_i) begin
      state_q  <= state_d;
      count_q  <= count_d;
      last_q   <= last_d;
      pins_q   <= pins_d;
      alert_q  <= alert_d;
      status_q <= status_d;
    end
  end

  assign res_o.motor_pins = pins_d;
  assign res_o.alert_led  = alert_d;
  assign res_o.status_led = status_d;
  assign res_o.drive_now  = state_d;

  // Step count only runs while reversing or turning
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (state_q == DRV_REV || state_q == DRV_RIGHT || state_q == DRV_LEFT))
    else $error("step count nonzero outside reverse/turn");

  // Stored sample follows every sample beat
  a_last_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && beat_i.mode == ModeSample) |=> (last_q == $past(beat_i.sample)))
    else $error("last sample not captured");

endmodule

// ----- hw/rtl/obstacle_avoid_drive_sequencer.sv -----
// Obstacle-avoid drive sequencer: one event in, one result out per beat.
// The drive step decode sits between the state registers and a single result
// register, so a new event is accepted every cycle as long as the result register
// is empty or being drained that cycle. The result beat is registered and appears
// in the cycle after its input beat is accepted. Configuration writes take effect
// on the next clock edge.
// Depends on oads_pkg, oads_cfg_regs and oads_drive_core.
module obstacle_avoid_drive_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [oads_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [oads_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  oads_pkg::in_beat_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output oads_pkg::out_beat_t              out_data_o
);
  import oads_pkg::*;

  cfg_t      cfg;
  out_beat_t res;
  out_beat_t res_q;
  logic      out_valid_q, out_valid_d;
  logic      in_fire;

  oads_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  oads_drive_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (in_fire),
    .beat_i (in_data_i),
    .res_o  (res)
  );

  // Result register frees up when drained in the same cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  // Result register tracks the core's levels from reset on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_q <= '0;
    else if (in_fire) res_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !in_fire)
    else $error("pending result overwritten");

  // Alert only toggles on a sample beat that handles stop
  a_alert_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (res.alert_led != res_q.alert_led)) |->
      (in_data_i.mode == ModeSample && res.drive_now == DRV_REV))
    else $error("alert toggled outside stop handling");

endmodule

// ----- verif/obstacle_avoid_drive_sequencer_test.sv -----
// Self-checking testbench for the obstacle-avoid drive sequencer: directed event
// sequences, register writes and random traffic under sender gaps and receiver stalls.
// Depends on oads_pkg and the obstacle_avoid_drive_sequencer RTL.
`timescale 1ns / 1ps

module obstacle_avoid_drive_sequencer_test;
  import oads_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned MaxPrinted = 100;

  // Register index with no register behind it
  localparam logic [CfgIdxBits-1:0] RegUnused = 2'd3;

  // Motor pin patterns per drive state
  localparam logic [4:0] MaskEnable    = 5'h01;
  localparam logic [4:0] MaskFwdClear  = 5'h12;
  localparam logic [4:0] MaskFwdSet    = 5'h0D;
  localparam logic [4:0] MaskRevClear  = 5'h0C;
  localparam logic [4:0] MaskRevSet    = 5'h13;
  localparam logic [4:0] MaskRgtClear  = 5'h15;
  localparam logic [4:0] MaskRgtSet    = 5'h0B;
  localparam logic [4:0] MaskLftClear  = 5'h0B;
  localparam logic [4:0] MaskLftSet    = 5'h15;
  localparam logic [7:0] StepCountTop  = 8'hFF;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  in_beat_t               in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  out_beat_t              out_data_o;

  obstacle_avoid_drive_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Predicted drive state and configuration
  drive_e                drv_q;
  logic [7:0]            steps_q;
  logic [SampleBits-1:0] last_q;
  logic [4:0]            pins_q;
  logic                  alert_q;
  logic                  status_q;
  logic [ThreshBits-1:0] thresh_q;
  logic [7:0]            rev_lim_q;
  logic [7:0]            turn_lim_q;

  out_beat_t pending_beats[$];
  out_beat_t want_beat;
  int        errors;
  int        cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void reset_drive_model();
    drv_q      = DRV_FWD;
    steps_q    = '0;
    last_q     = '0;
    pins_q     = '0;
    alert_q    = 1'b0;
    status_q   = 1'b0;
    thresh_q   = 10'd400;
    rev_lim_q  = 8'd12;
    turn_lim_q = 8'd5;
  endfunction

  // Count one step in a timed state, leave once the count passes the limit
  function automatic void count_drive_step(logic [7:0] limit, drive_e next);
    if (steps_q != StepCountTop) steps_q = steps_q + 8'd1;
    if (steps_q > limit) begin
      drv_q   = next;
      steps_q = '0;
    end
  endfunction

  // Advance the predicted state by one event and return the result beat
  function automatic out_beat_t predict_drive(in_beat_t ev);
    out_beat_t res;
    if (ev.mode == ModeButton) begin
      status_q = ~status_q;
    end else begin
      last_q = ev.sample;
      if (ev.sample > thresh_q) begin
        status_q = ~status_q;
        if (drv_q == DRV_FWD) begin
          drv_q   = DRV_STOP;
          steps_q = '0;
        end
      end
      case (drv_q)
        DRV_STOP: begin
          pins_q  = pins_q & ~MaskEnable;
          drv_q   = DRV_REV;
          steps_q = '0;
          alert_q = ~alert_q;
        end
        DRV_FWD: begin
          pins_q = (pins_q & ~MaskFwdClear) | MaskFwdSet;
        end
        DRV_REV: begin
          if (steps_q == '0) pins_q = (pins_q & ~MaskRevClear) | MaskRevSet;
          count_drive_step(rev_lim_q, last_q[0] ? DRV_RIGHT : DRV_LEFT);
        end
        DRV_RIGHT: begin
          if (steps_q == '0) pins_q = (pins_q & ~MaskRgtClear) | MaskRgtSet;
          count_drive_step(turn_lim_q, DRV_FWD);
        end
        DRV_LEFT: begin
          if (steps_q == '0) pins_q = (pins_q & ~MaskLftClear) | MaskLftSet;
          count_drive_step(turn_lim_q, DRV_FWD);
        end
        default: begin
          drv_q = DRV_STOP;
        end
      endcase
    end
    res.motor_pins = pins_q;
    res.alert_led  = alert_q;
    res.status_led = status_q;
    res.drive_now  = drv_q;
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= MaxPrinted) $display("MISMATCH %s: got %0d, want %0d", what, got, want);
  endtask

  // Receiver stalls, changed at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checking and expectation capture at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        if (out_valid_o && !out_stall_i) begin
          if (pending_beats.size() == 0) begin
            report("result beat with none pending", int'(out_data_o), 0);
          end else begin
            want_beat = pending_beats.pop_front();
            if (out_data_o.motor_pins != want_beat.motor_pins)
              report("motor_pins", int'(out_data_o.motor_pins), int'(want_beat.motor_pins));
            if (out_data_o.alert_led != want_beat.alert_led)
              report("alert_led", int'(out_data_o.alert_led), int'(want_beat.alert_led));
            if (out_data_o.status_led != want_beat.status_led)
              report("status_led", int'(out_data_o.status_led), int'(want_beat.status_led));
            if (out_data_o.drive_now != want_beat.drive_now)
              report("drive_now", int'(out_data_o.drive_now), int'(want_beat.drive_now));
          end
        end
        if (in_valid_i && !in_stall_o) pending_beats.push_back(predict_drive(in_data_i));
      end
    end
  end

  // Send one event beat, with random idle cycles ahead of it
  task automatic send_event(input logic mode, input logic [SampleBits-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    in_data_i.mode   <= mode;
    in_data_i.sample <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegThreshold: thresh_q   = val[ThreshBits-1:0];
      RegRevLimit:  rev_lim_q  = val[7:0];
      RegTurnLimit: turn_lim_q = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [9:0] th, input logic [9:0] rl, input logic [9:0] tl);
    write_reg(RegThreshold, th);
    write_reg(RegRevLimit, rl);
    write_reg(RegTurnLimit, tl);
  endtask

  // Random event: mostly quiet samples so that turns run to completion
  task automatic send_random_event();
    logic                  mode;
    logic [SampleBits-1:0] smp;
    int                    pick;
    mode = ($urandom_range(99) < 12) ? ModeButton : ModeSample;
    pick = int'($urandom_range(9));
    if (pick < 2 && thresh_q != 10'h3FF)
      smp = SampleBits'($urandom_range(1023, int'(thresh_q) + 1));
    else if (pick == 2) smp = thresh_q;
    else if (pick == 3) smp = SampleBits'($urandom_range(1023));
    else smp = SampleBits'($urandom_range(int'(thresh_q)));
    send_event(mode, smp);
  endtask

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      send_random_event();
      if (i == n / 2 || $urandom_range(49) == 0) drain_results();
    end
    drain_results();
  endtask

  // Reset levels and defaults: button press, quiet sample, sample at threshold
  task automatic test_reset_state();
    send_event(ModeButton, 10'h3FF);
    send_event(ModeSample, 10'd0);
    send_event(ModeSample, 10'd400);
    drain_results();
  endtask

  // Write to the unused index must not disturb the default threshold
  task automatic test_register_map();
    write_reg(RegUnused, 10'h3FF);
    send_event(ModeSample, 10'd401);
    drain_results();
  endtask

  // Short limits: reverse into right turn, forward, stop, reverse into left turn
  task automatic test_obstacle_sequence();
    set_config(10'd400, 10'd1, 10'd0);
    send_event(ModeSample, 10'd3);
    send_event(ModeSample, 10'd1023);
    send_event(ModeSample, 10'd2);
    send_event(ModeSample, 10'd6);
    send_event(ModeButton, 10'd0);
    send_event(ModeSample, 10'd900);
    send_event(ModeSample, 10'd8);
    send_event(ModeSample, 10'd10);
    send_event(ModeButton, 10'h2AA);
    send_event(ModeSample, 10'd12);
    send_event(ModeSample, 10'd20);
    drain_results();
  endtask

  // Threshold at both ends of its range
  task automatic test_threshold_extremes();
    write_reg(RegThreshold, 10'd0);
    send_event(ModeSample, 10'd0);
    send_event(ModeSample, 10'd1);
    drain_results();
    write_reg(RegThreshold, 10'h3FF);
    send_event(ModeSample, 10'h3FF);
    send_event(ModeSample, 10'h155);
    drain_results();
  endtask

  // Random traffic over several settings and idle patterns
  task automatic test_random_traffic();
    set_config(10'd400, 10'd12, 10'd5);
    run_random(40, 0, 0);
    set_config(10'd0, 10'd0, 10'd0);
    run_random(35, 80, 0);
    set_config(10'h3FF, 10'd7, 10'd3);
    run_random(30, 0, 80);
    set_config(10'd600, 10'd2, 10'd1);
    run_random(35, 30, 30);
  endtask

  // Limit of all ones: the step counter sticks at its top and reverse holds
  task automatic test_counter_saturation();
    set_config(10'd300, 10'h3FF, 10'd0);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    // Two close samples land in reverse from any settled state
    send_event(ModeSample, 10'd900);
    send_event(ModeSample, 10'd900);
    for (int i = 0; i < 262; i++) begin
      send_event(ModeSample, SampleBits'($urandom_range(300)));
    end
    drain_results();
    set_config(10'd500, 10'd1, 10'd2);
    run_random(30, 0, 0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    errors         = 0;
    cycles         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    reset_drive_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_register_map();
    test_obstacle_sequence();
    test_threshold_extremes();
    test_random_traffic();
    test_counter_saturation();

    drain_results();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
